### hw/rtl/tcpu_pkg.sv
// Package for the 16-bit core: modes, opcodes, ALU ops, error codes, command and status types.
// No dependencies.
`default_nettype none
package tcpu_pkg;
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_EXEC = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic [3:0] OP_MOV = 4'd0;
   localparam logic [3:0] OP_LDV = 4'd1;
   localparam logic [3:0] OP_LDA = 4'd2;
   localparam logic [3:0] OP_LDM = 4'd3;
   localparam logic [3:0] OP_LDR = 4'd4;
   localparam logic [3:0] OP_LDP = 4'd5;
   localparam logic [3:0] OP_ATH = 4'd6;
   localparam logic [3:0] OP_CAL = 4'd7;
   localparam logic [3:0] OP_RET = 4'd8;
   localparam logic [3:0] OP_JLT = 4'd9;
   localparam logic [3:0] OP_PSH = 4'd10;
   localparam logic [3:0] OP_POP = 4'd11;
   localparam logic [3:0] OP_SYS = 4'd12;
   localparam logic [3:0] OP_HLT = 4'd13;
   localparam logic [3:0] OP_JMP = 4'd14;
   localparam logic [3:0] OP_JMR = 4'd15;

   localparam logic [3:0] ALU_ADD = 4'd0;
   localparam logic [3:0] ALU_SUB = 4'd1;
   localparam logic [3:0] ALU_MUL = 4'd2;
   localparam logic [3:0] ALU_DIV = 4'd3;
   localparam logic [3:0] ALU_LSH = 4'd4;
   localparam logic [3:0] ALU_RSH = 4'd5;
   localparam logic [3:0] ALU_AND = 4'd6;
   localparam logic [3:0] ALU_OR  = 4'd7;
   localparam logic [3:0] ALU_XOR = 4'd8;
   localparam logic [3:0] ALU_NOT = 4'd9;
   localparam logic [3:0] ALU_INC = 4'd10;
   localparam logic [3:0] ALU_DEC = 4'd11;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_ALU   = 2'd1;
   localparam logic [1:0] ERR_OVER  = 2'd2;
   localparam logic [1:0] ERR_UNDER = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic mem_rd_req;    // read memory at req address
      logic mem_wr_req;    // write req data at req address
      logic fetch;         // read memory at pc
      logic decode;        // latch instruction, read operands
      logic opnd_read;     // read memory at operand address (LDA/LDR)
      logic execute;       // perform non-divide effects
      logic div_start;
      logic div_step;
      logic div_finish;    // write divide result
      logic finish;        // latch read word for output
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_opnd;     // instruction reads data memory
      logic is_div;        // ALU divide (with nonzero divisor)
      logic div_done;
      logic halted;
   } stat_type;
endpackage
`default_nettype wire

### hw/rtl/tcpu_ctrl.sv
// Controller state machine of the 16-bit core.
// Uses tcpu_pkg.
`default_nettype none
module tcpu_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tcpu_pkg::cmd_type      cmd,
   input  tcpu_pkg::stat_type     stat
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MEM    = 9'b000000010,
      ST_FETCH  = 9'b000000100,
      ST_DECODE = 9'b000001000,
      ST_OPND   = 9'b000010000,
      ST_EXEC   = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_FIN    = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == tcpu_pkg::MODE_EXEC && !stat.halted) begin
                  state_in = ST_FETCH;
                  cmd.fetch = 1'b1;
               end else begin
                  state_in = ST_MEM;
                  cmd.mem_rd_req = (req_mode == tcpu_pkg::MODE_READ);
                  cmd.mem_wr_req = (req_mode == tcpu_pkg::MODE_LOAD);
               end
            end
         end
         ST_MEM: begin
            state_in = ST_FIN;
         end
         ST_FETCH: begin
            cmd.decode = 1'b1;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (stat.need_opnd) begin
               cmd.opnd_read = 1'b1;
               state_in = ST_OPND;
            end else if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.execute = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_OPND: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in = ST_FIN;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.div_finish = 1'b1;
               state_in = ST_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

### hw/rtl/tcpu_dpath.sv
// Datapath of the 16-bit core: word memory, registers, stack, ALU, divider.
// Uses tcpu_pkg.
`default_nettype none
module tcpu_dpath #(
   parameter int MEM_WORDS   = 1024,
   parameter int STACK_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [9:0]    req_mem_addr,
   input  wire logic [15:0]   req_mem_data,
   input  tcpu_pkg::cmd_type  cmd,
   output tcpu_pkg::stat_type stat,
   output logic [15:0]        rsp_read_word,
   output logic [15:0]        rsp_program_counter,
   output logic               rsp_halted,
   output logic [1:0]         rsp_error_code
);
   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [15:0] mem [MEM_WORDS];
   logic [15:0] stk [STACK_DEPTH];

   logic [15:0] rf_ff [4];
   logic [AW-1:0] pc_ff;
   logic [CW-1:0] sc_ff;
   logic          stop_ff;
   logic [1:0]    err_ff;
   logic [15:0]   rdata_ff;   // registered memory read
   logic [15:0]   ins_ff;
   logic [15:0]   s_ff, d_ff, r0_ff, top_ff;
   logic          rd_out_ff;  // read mode pending
   logic [15:0]   out_word_ff;

   // memory port
   logic          mwe;
   logic [AW-1:0] maddr_w, maddr_r;
   logic [15:0]   mwdata;
   logic          mre;

   // decode
   logic [3:0] opc, aop;
   logic [1:0] dst, src;
   logic [9:0] imm;
   logic       to_src;
   logic [2:0] sh;
   assign opc    = ins_ff[3:0];
   assign dst    = ins_ff[5:4];
   assign src    = ins_ff[7:6];
   assign imm    = ins_ff[15:6];
   assign aop    = ins_ff[11:8];
   assign to_src = ins_ff[12];
   assign sh     = ins_ff[15:13];

   // divider
   logic [15:0] q_ff, rem_ff;
   logic [4:0]  dcnt_ff;
   logic [16:0] trial;
   assign trial = {rem_ff, q_ff[15]} - {1'b0, s_ff};

   assign stat.need_opnd = (opc == tcpu_pkg::OP_LDA) || (opc == tcpu_pkg::OP_LDR);
   assign stat.is_div    = (opc == tcpu_pkg::OP_ATH) && (aop == tcpu_pkg::ALU_DIV)
                           && (s_ff != 16'd0);
   assign stat.div_done  = (dcnt_ff == 5'd16);
   assign stat.halted    = stop_ff;

   // ALU
   logic [31:0] prod;
   logic [15:0] alu_res;
   logic        alu_ok;
   assign prod = d_ff * s_ff;
   always_comb begin
      alu_ok = 1'b1;
      case (aop)
         tcpu_pkg::ALU_ADD: alu_res = d_ff + s_ff;
         tcpu_pkg::ALU_SUB: alu_res = d_ff - s_ff;
         tcpu_pkg::ALU_MUL: alu_res = prod[15:0];
         tcpu_pkg::ALU_DIV: alu_res = 16'hFFFF;   // zero divisor only here
         tcpu_pkg::ALU_LSH: alu_res = s_ff << sh;
         tcpu_pkg::ALU_RSH: alu_res = s_ff >> sh;
         tcpu_pkg::ALU_AND: alu_res = d_ff & s_ff;
         tcpu_pkg::ALU_OR:  alu_res = d_ff | s_ff;
         tcpu_pkg::ALU_XOR: alu_res = d_ff ^ s_ff;
         tcpu_pkg::ALU_NOT: alu_res = ~s_ff;
         tcpu_pkg::ALU_INC: alu_res = d_ff + 16'd1;
         tcpu_pkg::ALU_DEC: alu_res = d_ff - 16'd1;
         default: begin
            alu_res = 16'd0;
            alu_ok  = 1'b0;
         end
      endcase
   end

   logic full, empty;
   assign full  = (sc_ff >= CW'(STACK_DEPTH));
   assign empty = (sc_ff == '0);
   logic [SW-1:0] sp_push, sp_pop;
   assign sp_push = SW'(sc_ff);
   assign sp_pop  = SW'(sc_ff - CW'(1));

   // memory control
   always_comb begin
      mwe     = 1'b0;
      maddr_w = AW'(req_mem_addr);
      mwdata  = req_mem_data;
      mre     = 1'b0;
      maddr_r = AW'(req_mem_addr);
      if (cmd.mem_wr_req) mwe = 1'b1;
      if (cmd.mem_rd_req) mre = 1'b1;
      if (cmd.fetch) begin
         mre = 1'b1;
         maddr_r = pc_ff;
      end
      if (cmd.opnd_read) begin
         mre = 1'b1;
         maddr_r = (opc == tcpu_pkg::OP_LDA) ? AW'(imm) : AW'(s_ff);
      end
      if (cmd.execute && opc == tcpu_pkg::OP_LDM) begin
         mwe = 1'b1;
         maddr_w = AW'(imm);
         mwdata = d_ff;
      end
      if (cmd.execute && opc == tcpu_pkg::OP_LDP) begin
         mwe = 1'b1;
         maddr_w = AW'(d_ff);
         mwdata = s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mwe) mem[maddr_w] <= mwdata;
      if (mre) rdata_ff <= mem[maddr_r];
   end

   // stack memory, read of top is registered at decode
   logic          stk_we;
   logic [15:0]   stk_wd;
   assign stk_we = cmd.execute && !full &&
                   (opc == tcpu_pkg::OP_CAL || opc == tcpu_pkg::OP_PSH);
   assign stk_wd = (opc == tcpu_pkg::OP_CAL) ? 16'(pc_ff) : s_ff;
   always_ff @(posedge clock) begin
      if (stk_we) stk[sp_push] <= stk_wd;
      if (cmd.decode) top_ff <= stk[sp_pop];
   end

   // operand latch; operands come from the instruction word arriving now
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         ins_ff <= rdata_ff;
         s_ff   <= rf_ff[rdata_ff[7:6]];
         d_ff   <= rf_ff[rdata_ff[5:4]];
         r0_ff  <= rf_ff[0];
      end
      if (cmd.div_start) begin
         q_ff    <= d_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial[16]) rem_ff <= trial[15:0];
         else            rem_ff <= {rem_ff[14:0], q_ff[15]};
         q_ff    <= {q_ff[14:0], !trial[16]};
         dcnt_ff <= dcnt_ff + 5'd1;
      end
   end

   // next pc for a completing instruction; faults keep the pc in place
   logic [AW-1:0] pc_next;
   always_comb begin
      pc_next = pc_ff + AW'(1);
      case (opc)
         tcpu_pkg::OP_CAL: pc_next = AW'(d_ff);
         tcpu_pkg::OP_RET: pc_next = AW'(top_ff + 16'd1);
         tcpu_pkg::OP_JLT: if (r0_ff < d_ff) pc_next = AW'(s_ff);
         tcpu_pkg::OP_JMP: pc_next = AW'(imm);
         tcpu_pkg::OP_JMR: pc_next = AW'(s_ff);
         default: ;
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) rf_ff[i] <= '0;
         pc_ff   <= '0;
         sc_ff   <= '0;
         stop_ff <= 1'b0;
         err_ff  <= tcpu_pkg::ERR_NONE;
      end else begin
         if (cmd.div_finish) begin
            if (to_src) rf_ff[src] <= q_ff;
            else        rf_ff[dst] <= q_ff;
            pc_ff <= pc_ff + AW'(1);
         end
         if (cmd.execute) begin
            case (opc)
               tcpu_pkg::OP_MOV: rf_ff[dst] <= s_ff;
               tcpu_pkg::OP_LDV: rf_ff[dst] <= 16'(imm);
               tcpu_pkg::OP_LDA: rf_ff[dst] <= rdata_ff;
               tcpu_pkg::OP_LDR: rf_ff[dst] <= rdata_ff;
               tcpu_pkg::OP_ATH: begin
                  if (alu_ok) begin
                     if (to_src) rf_ff[src] <= alu_res;
                     else        rf_ff[dst] <= alu_res;
                  end
               end
               tcpu_pkg::OP_CAL: if (!full) sc_ff <= sc_ff + CW'(1);
               tcpu_pkg::OP_RET: if (!empty) sc_ff <= sc_ff - CW'(1);
               tcpu_pkg::OP_PSH: if (!full) sc_ff <= sc_ff + CW'(1);
               tcpu_pkg::OP_POP: if (!empty) begin
                  sc_ff <= sc_ff - CW'(1);
                  rf_ff[dst] <= top_ff;
               end
               default: ;
            endcase
            if (opc == tcpu_pkg::OP_HLT) begin
               stop_ff <= 1'b1;
            end else if (opc == tcpu_pkg::OP_ATH && !alu_ok) begin
               stop_ff <= 1'b1;
               err_ff  <= tcpu_pkg::ERR_ALU;
            end else if ((opc == tcpu_pkg::OP_CAL || opc == tcpu_pkg::OP_PSH) && full) begin
               stop_ff <= 1'b1;
               err_ff  <= tcpu_pkg::ERR_OVER;
            end else if ((opc == tcpu_pkg::OP_RET || opc == tcpu_pkg::OP_POP) && empty) begin
               stop_ff <= 1'b1;
               err_ff  <= tcpu_pkg::ERR_UNDER;
            end else begin
               pc_ff <= pc_next;
            end
         end
      end
   end

   // read word is nonzero only for a read item; flag clears once the word is latched
   always_ff @(posedge clock) begin
      if (reset)               rd_out_ff <= 1'b0;
      else if (cmd.mem_rd_req) rd_out_ff <= 1'b1;
      else if (cmd.finish)     rd_out_ff <= 1'b0;
      if (cmd.finish) out_word_ff <= rd_out_ff ? rdata_ff : 16'd0;
   end

   assign rsp_read_word       = out_word_ff;
   assign rsp_program_counter = 16'(pc_ff);
   assign rsp_halted          = stop_ff;
   assign rsp_error_code      = err_ff;
endmodule
`default_nettype wire

### hw/rtl/tiny_cpu_16bit_core.sv
// Top level of the 16-bit four-register core: controller plus datapath.
// Uses tcpu_pkg, tcpu_ctrl, tcpu_dpath.
//
//   channel | direction | ports
//   req     | in        | req_valid/req_ready, req_mode, req_mem_addr, req_mem_data
//   rsp     | out       | rsp_valid/rsp_ready, rsp_read_word, rsp_program_counter,
//           |           | rsp_halted, rsp_error_code
//
// One item at a time. Load/read items pass through idle, mem, finish, out.
// Execute passes through idle, fetch, decode, finish, out; LDA/LDR add opnd and exec
// (second memory read on the single read port), and a DIV adds the div state (16-step
// restoring divider). The response register holds until the transfer;
// req_ready is low meanwhile.
// Synchronous active-high reset clears registers, PC, stack count and status;
// word and stack memories are not cleared.
`default_nettype none
module tiny_cpu_16bit_core #(
   parameter int MEM_WORDS   = 1024,
   parameter int STACK_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [9:0]  req_mem_addr,
   input  wire logic [15:0] req_mem_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_read_word,
   output logic [15:0]      rsp_program_counter,
   output logic             rsp_halted,
   output logic [1:0]       rsp_error_code
);
   tcpu_pkg::cmd_type  cmd;
   tcpu_pkg::stat_type stat;

   tcpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // mode 3 and execute on a stopped core pass through the memory state
   // with neither read nor write, so they report a zero read word
   tcpu_dpath #(
      .MEM_WORDS   (MEM_WORDS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_mem_addr        (req_mem_addr),
      .req_mem_data        (req_mem_data),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_read_word       (rsp_read_word),
      .rsp_program_counter (rsp_program_counter),
      .rsp_halted          (rsp_halted),
      .rsp_error_code      (rsp_error_code)
   );
endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for tiny_cpu_16bit_core: a scoreboard class predicts each
// transfer's response, plain tasks drive requests. Depends on tcpu_pkg and the RTL.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] read_word;
      logic [15:0] pc;
      logic        halted;
      logic [1:0]  err;
   } cpu_rsp_type;

   // Scoreboard: holds its own copy of the core state and the queue of
   // responses still owed by the DUT.
   class cpu_scoreboard;
      logic [15:0] regs [4];
      logic [15:0] pc;
      logic [15:0] mem [1024];
      bit          written [1024];
      int          written_list [$];
      logic [15:0] stk [16];
      int          depth;
      bit          stopped;
      logic [1:0]  err;
      cpu_rsp_type pending [$];
      int          failures;

      function new();
         for (int i = 0; i < 4; i++) regs[i] = '0;
         for (int i = 0; i < 1024; i++) written[i] = 0;
         pc = '0;
         depth = 0;
         stopped = 0;
         err = tcpu_pkg::ERR_NONE;
         failures = 0;
      endfunction

      function void store(int a, logic [15:0] d);
         mem[a] = d;
         if (!written[a]) begin
            written[a] = 1;
            written_list.push_back(a);
         end
      endfunction

      function void stop_with(logic [1:0] code);
         err = code;
         stopped = 1;
      endfunction

      function void run_one();
         logic [15:0] ins, s, d, res;
         logic [3:0]  opc, aop;
         logic [1:0]  dsel, ssel;
         logic [9:0]  imm;
         logic [2:0]  sh;
         bit          ok;
         int          nxt;
         ins  = mem[pc % 1024];
         opc  = ins[3:0];
         dsel = ins[5:4];
         ssel = ins[7:6];
         imm  = ins[15:6];
         aop  = ins[11:8];
         sh   = ins[15:13];
         nxt  = pc + 1;
         s    = regs[ssel];
         d    = regs[dsel];
         case (opc)
            tcpu_pkg::OP_MOV: regs[dsel] = s;
            tcpu_pkg::OP_LDV: regs[dsel] = {6'd0, imm};
            tcpu_pkg::OP_LDA: regs[dsel] = mem[imm];
            tcpu_pkg::OP_LDM: store(imm, d);
            tcpu_pkg::OP_LDR: regs[dsel] = mem[s % 1024];
            tcpu_pkg::OP_LDP: store(d % 1024, s);
            tcpu_pkg::OP_ATH: begin
               ok = 1;
               case (aop)
                  tcpu_pkg::ALU_ADD: res = d + s;
                  tcpu_pkg::ALU_SUB: res = d - s;
                  tcpu_pkg::ALU_MUL: res = d * s;
                  tcpu_pkg::ALU_DIV: res = (s == 0) ? 16'hFFFF : d / s;
                  tcpu_pkg::ALU_LSH: res = s << sh;
                  tcpu_pkg::ALU_RSH: res = s >> sh;
                  tcpu_pkg::ALU_AND: res = d & s;
                  tcpu_pkg::ALU_OR:  res = d | s;
                  tcpu_pkg::ALU_XOR: res = d ^ s;
                  tcpu_pkg::ALU_NOT: res = ~s;
                  tcpu_pkg::ALU_INC: res = d + 16'd1;
                  tcpu_pkg::ALU_DEC: res = d - 16'd1;
                  default: ok = 0;
               endcase
               if (!ok) begin
                  stop_with(tcpu_pkg::ERR_ALU);
                  return;
               end
               if (ins[12]) regs[ssel] = res;
               else regs[dsel] = res;
            end
            tcpu_pkg::OP_CAL: begin
               if (depth >= 16) begin
                  stop_with(tcpu_pkg::ERR_OVER);
                  return;
               end
               stk[depth] = pc;
               depth++;
               nxt = d;
            end
            tcpu_pkg::OP_RET: begin
               if (depth == 0) begin
                  stop_with(tcpu_pkg::ERR_UNDER);
                  return;
               end
               depth--;
               nxt = stk[depth] + 1;
            end
            tcpu_pkg::OP_JLT: if (regs[0] < d) nxt = s;
            tcpu_pkg::OP_PSH: begin
               if (depth >= 16) begin
                  stop_with(tcpu_pkg::ERR_OVER);
                  return;
               end
               stk[depth] = s;
               depth++;
            end
            tcpu_pkg::OP_POP: begin
               if (depth == 0) begin
                  stop_with(tcpu_pkg::ERR_UNDER);
                  return;
               end
               depth--;
               regs[dsel] = stk[depth];
            end
            tcpu_pkg::OP_SYS: ;
            tcpu_pkg::OP_HLT: begin
               stopped = 1;
               return;
            end
            tcpu_pkg::OP_JMP: nxt = imm;
            default: nxt = s;
         endcase
         pc = nxt % 1024;
      endfunction

      function void note_item(logic [1:0] mode, logic [9:0] addr, logic [15:0] data);
         cpu_rsp_type r;
         r.read_word = '0;
         if (mode == tcpu_pkg::MODE_LOAD) store(addr, data);
         else if (mode == tcpu_pkg::MODE_EXEC) begin
            if (!stopped) run_one();
         end else if (mode == tcpu_pkg::MODE_READ) r.read_word = mem[addr];
         r.pc = pc;
         r.halted = stopped;
         r.err = err;
         pending.push_back(r);
      endfunction

      function void check_result(logic [15:0] rw, logic [15:0] pcv, logic h,
                                 logic [1:0] e);
         cpu_rsp_type x;
         if (pending.size() == 0) begin
            $error("response with nothing outstanding");
            failures++;
            return;
         end
         x = pending.pop_front();
         if (rw !== x.read_word) begin
            $error("read_word expected %h got %h", x.read_word, rw);
            failures++;
         end
         if (pcv !== x.pc) begin
            $error("program_counter expected %h got %h", x.pc, pcv);
            failures++;
         end
         if (h !== x.halted) begin
            $error("halted expected %b got %b", x.halted, h);
            failures++;
         end
         if (e !== x.err) begin
            $error("error_code expected %0d got %0d", x.err, e);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [9:0]  req_mem_addr = '0;
   logic [15:0] req_mem_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_read_word;
   logic [15:0] rsp_program_counter;
   logic        rsp_halted;
   logic [1:0]  rsp_error_code;

   cpu_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int sent = 0;

   tiny_cpu_16bit_core u_top (.*);

   always #2 clock = ~clock;

   // receiver backpressure, one draw per cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_read_word, rsp_program_counter, rsp_halted, rsp_error_code);
   end

   // one request transfer; valid stays up afterwards unless the next call idles
   task automatic send(logic [1:0] mode, logic [9:0] addr, logic [15:0] data);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1;
      req_mode     <= mode;
      req_mem_addr <= addr;
      req_mem_data <= data;
      do @(posedge clock); while (!req_ready);
      sb.note_item(mode, addr, data);
      sent++;
   endtask

   // true if the word would run without stopping the core
   function automatic bit runs_clean(logic [15:0] ins);
      case (ins[3:0])
         tcpu_pkg::OP_HLT: return 0;
         tcpu_pkg::OP_ATH: return ins[11:8] <= tcpu_pkg::ALU_DEC;
         tcpu_pkg::OP_CAL, tcpu_pkg::OP_PSH: return sb.depth < 16;
         tcpu_pkg::OP_RET, tcpu_pkg::OP_POP: return sb.depth > 0;
         default: return 1;
      endcase
   endfunction

   // true if every memory word the instruction reads has been written
   function automatic bit operands_ready(logic [15:0] ins);
      if (ins[3:0] == tcpu_pkg::OP_LDA) return sb.written[ins[15:6]];
      if (ins[3:0] == tcpu_pkg::OP_LDR) return sb.written[sb.regs[ins[7:6]] % 1024];
      return 1;
   endfunction

   // place ins at the PC, back-fill any unwritten operand word, then run it
   task automatic run_ins(logic [15:0] ins);
      int a;
      send(tcpu_pkg::MODE_LOAD, sb.pc[9:0], ins);
      if (ins[3:0] == tcpu_pkg::OP_LDA) a = ins[15:6];
      else a = sb.regs[ins[7:6]] % 1024;
      if (!operands_ready(ins)) send(tcpu_pkg::MODE_LOAD, a[9:0], 16'($urandom));
      send(tcpu_pkg::MODE_EXEC, '0, 16'($urandom));
   endtask

   function automatic logic [15:0] pick_ins(logic [3:0] opc);
      logic [15:0] w;
      w = 16'($urandom);
      w[3:0] = opc;
      if (opc == tcpu_pkg::OP_ATH) w[11:8] = 4'($urandom_range(0, 11));
      return w;
   endfunction

   task automatic run_op(logic [3:0] opc);
      logic [15:0] w;
      w = pick_ins(opc);
      if (runs_clean(w)) run_ins(w);
   endtask

   task automatic read_written();
      int a;
      a = sb.written_list[$urandom_range(0, sb.written_list.size() - 1)];
      send(tcpu_pkg::MODE_READ, a[9:0], 16'($urandom));
   endtask

   task automatic random_step();
      int r;
      logic [15:0] w;
      r = $urandom_range(0, 99);
      if (r < 6) send(tcpu_pkg::MODE_LOAD, 10'($urandom), 16'($urandom));
      else if (r < 12) read_written();
      else if (r < 14) send(tcpu_pkg::MODE_NONE, 10'($urandom), 16'($urandom));
      else if (r < 30 && sb.written[sb.pc] && runs_clean(sb.mem[sb.pc])
               && operands_ready(sb.mem[sb.pc]))
         // run whatever the program left at the PC
         send(tcpu_pkg::MODE_EXEC, 10'($urandom), 16'($urandom));
      else begin
         do w = pick_ins(4'($urandom)); while (!runs_clean(w));
         run_ins(w);
      end
   endtask

   // drive the core into one of its four stop conditions
   task automatic stop_core();
      logic [15:0] w;
      case ($urandom_range(0, 3))
         0: run_ins(pick_ins(tcpu_pkg::OP_HLT));
         1: begin
            w = pick_ins(tcpu_pkg::OP_ATH);
            w[11:8] = 4'($urandom_range(12, 15));
            run_ins(w);
         end
         2: begin
            while (sb.depth < 16) run_ins(pick_ins(tcpu_pkg::OP_PSH));
            run_ins(pick_ins(tcpu_pkg::OP_PSH));
         end
         default: begin
            while (sb.depth > 0) run_ins(pick_ins(tcpu_pkg::OP_POP));
            run_ins(pick_ins(tcpu_pkg::OP_RET));
         end
      endcase
   endtask

   initial begin
      bit paused;
      paused = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, unused mode, every opcode but HLT and every ALU op
      send(tcpu_pkg::MODE_LOAD, 10'd0, 16'h0000);
      send(tcpu_pkg::MODE_LOAD, 10'd1023, 16'hFFFF);
      send(tcpu_pkg::MODE_READ, 10'd0, 16'hFFFF);
      send(tcpu_pkg::MODE_READ, 10'd1023, 16'h0000);
      send(tcpu_pkg::MODE_NONE, 10'd1023, 16'hFFFF);
      run_ins({10'd0, 2'd1, tcpu_pkg::OP_LDV});        // r1 = 0
      run_ins({10'd1023, 2'd2, tcpu_pkg::OP_LDV});     // r2 = 1023
      // divide by zero
      run_ins({3'd0, 1'b0, tcpu_pkg::ALU_DIV, 2'd1, 2'd2, tcpu_pkg::OP_ATH});
      for (int op = 0; op <= 11; op++) begin
         logic [15:0] w;
         w = pick_ins(tcpu_pkg::OP_ATH);
         w[11:8] = op[3:0];
         run_ins(w);
      end
      run_op(tcpu_pkg::OP_PSH);
      run_op(tcpu_pkg::OP_POP);
      run_op(tcpu_pkg::OP_CAL);
      run_op(tcpu_pkg::OP_RET);
      run_op(tcpu_pkg::OP_MOV); run_op(tcpu_pkg::OP_LDA); run_op(tcpu_pkg::OP_LDM);
      run_op(tcpu_pkg::OP_LDR); run_op(tcpu_pkg::OP_LDP); run_op(tcpu_pkg::OP_JLT);
      run_op(tcpu_pkg::OP_SYS); run_op(tcpu_pkg::OP_JMP); run_op(tcpu_pkg::OP_JMR);

      // random phases with different idling mixes
      send_idle_pct = 30;
      recv_idle_pct = 68;
      while (sent < 500) begin
         if (sent >= 200 && send_idle_pct == 30) begin
            send_idle_pct = 68;
            recv_idle_pct = 30;
         end
         if (sent >= 380 && send_idle_pct == 68) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (sent >= 300 && !paused) begin
            // hold off until the core has drained
            paused = 1;
            req_valid <= 0;
            while (sb.pending.size() > 0) @(posedge clock);
         end
         random_step();
      end

      // stop the core, then show loads and reads still work and execute items do nothing while stopped
      stop_core();
      send(tcpu_pkg::MODE_EXEC, 10'($urandom), 16'($urandom));
      send(tcpu_pkg::MODE_LOAD, 10'($urandom), 16'($urandom));
      read_written();
      send(tcpu_pkg::MODE_EXEC, 10'($urandom), 16'($urandom));
      req_valid <= 0;

      while (sb.pending.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0)
         $display("tiny_cpu_16bit_core verification clean");
      else
         $display("tiny_cpu_16bit_core verification failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("tiny_cpu_16bit_core verification failed");
      $finish;
   end
endmodule
`default_nettype wire
